@@ rtl/core/tplc_pkg.sv @@
// Package with the shared types and constants of the two-point level calibration block.
`timescale 1ns / 1ps
`default_nettype none

package tplc_pkg;

	// Channel count and field widths.
	localparam int CHANNELS       = 3;
	localparam int SAMPLE_BITS    = 12;
	localparam int TARGET_BITS    = 8;
	localparam int LEVEL_BITS     = 8;
	localparam int GAIN_FRAC_BITS = 16;
	localparam int GAIN_BITS      = LEVEL_BITS + GAIN_FRAC_BITS;
	localparam int PROD_BITS      = GAIN_BITS + SAMPLE_BITS;
	localparam int DIV_STEPS      = GAIN_BITS;
	localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

	// Levels and calibration targets.
	localparam logic [LEVEL_BITS-1:0]  LEVEL_MAX   = '1;
	localparam logic [TARGET_BITS-1:0] TARGET_LOW  = 8'd0;
	localparam logic [TARGET_BITS-1:0] TARGET_HIGH = 8'd255;

	// Divider dividend: full scale in gain format.
	localparam logic [GAIN_BITS-1:0] DIVIDEND = {LEVEL_MAX, {GAIN_FRAC_BITS{1'b0}}};

	// Reset values; gains are given with sixteen fraction bits and rescaled.
	localparam int RESET_FRAC = 16;
	localparam int GAIN_UP    = (GAIN_FRAC_BITS >= RESET_FRAC) ? GAIN_FRAC_BITS - RESET_FRAC : 0;
	localparam int GAIN_DOWN  = (GAIN_FRAC_BITS < RESET_FRAC) ? RESET_FRAC - GAIN_FRAC_BITS : 0;

	localparam logic [SAMPLE_BITS-1:0] RESET_LOW [8] = '{
		12'd1, 12'd1, 12'd1, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
	localparam logic [SAMPLE_BITS-1:0] RESET_HIGH [8] = '{
		12'd64, 12'd111, 12'd81, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
	localparam logic [31:0] RESET_GAIN_Q16 [8] = '{
		32'd265264, 32'd151924, 32'd208896, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};

	// Input beat.
	typedef struct packed {
		logic                   kind;
		logic [SAMPLE_BITS-1:0] sample_red;
		logic [SAMPLE_BITS-1:0] sample_green;
		logic [SAMPLE_BITS-1:0] sample_blue;
		logic [TARGET_BITS-1:0] target_red;
		logic [TARGET_BITS-1:0] target_green;
		logic [TARGET_BITS-1:0] target_blue;
	} in_t;

	// Output beat.
	typedef struct packed {
		logic [LEVEL_BITS-1:0] out_red;
		logic [LEVEL_BITS-1:0] out_green;
		logic [LEVEL_BITS-1:0] out_blue;
	} out_t;

	// Item kinds.
	localparam logic KIND_APPLY = 1'b0;
	localparam logic KIND_CAL   = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_load;
		logic cal_load;
		logic div_step;
		logic gain_write;
		logic mul;
		logic out_load;
	} tplc_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/tplc_datapath.sv @@
// Datapath: level and gain registers, per-channel serial dividers, multipliers, result register.
`timescale 1ns / 1ps
`default_nettype none

module tplc_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tplc_pkg::tplc_cmd_t cmd,
	input  wire tplc_pkg::in_t      in_data,
	output tplc_pkg::out_t          out_data
);

	localparam int CH = tplc_pkg::CHANNELS;
	localparam int SB = tplc_pkg::SAMPLE_BITS;
	localparam int GB = tplc_pkg::GAIN_BITS;
	localparam int PB = tplc_pkg::PROD_BITS;
	localparam int FB = tplc_pkg::GAIN_FRAC_BITS;
	localparam int LB = tplc_pkg::LEVEL_BITS;

	logic [SB-1:0]                   samp_q [CH];
	logic [tplc_pkg::TARGET_BITS-1:0] targ_q [CH];
	logic [SB-1:0]                   low_q  [CH];
	logic [SB-1:0]                   high_q [CH];
	logic [GB-1:0]                   gain_q [CH];
	logic [SB-1:0]                   rem_q  [CH];
	logic [GB-1:0]                   quo_q  [CH];
	logic [SB-1:0]                   dvs_q  [CH];
	logic                            upd_q  [CH];
	logic [PB-1:0]                   prod_s1 [CH];
	logic [LB-1:0]                   level_q [CH];

	logic [SB-1:0] new_low  [CH];
	logic [SB-1:0] new_high [CH];
	logic [SB:0]   trial    [CH];
	logic          ge       [CH];
	logic [SB-1:0] rem_next [CH];

	// Levels after the stored calibration beat is applied.
	always_comb begin
		for (int c = 0; c < CH; c++) begin
			new_low[c]  = low_q[c];
			new_high[c] = high_q[c];
			if (targ_q[c] == tplc_pkg::TARGET_LOW) begin
				new_low[c] = samp_q[c];
			end else if (targ_q[c] == tplc_pkg::TARGET_HIGH) begin
				new_high[c] = samp_q[c];
			end
		end
	end

	// One restoring division step per lane.
	always_comb begin
		for (int c = 0; c < CH; c++) begin
			trial[c]    = {rem_q[c], quo_q[c][GB-1]};
			ge[c]       = trial[c] >= {1'b0, dvs_q[c]};
			rem_next[c] = ge[c] ? SB'(trial[c] - {1'b0, dvs_q[c]}) : trial[c][SB-1:0];
		end
	end

	// Input beat capture.
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			samp_q[0] <= in_data.sample_red;
			samp_q[1] <= in_data.sample_green;
			samp_q[2] <= in_data.sample_blue;
			targ_q[0] <= in_data.target_red;
			targ_q[1] <= in_data.target_green;
			targ_q[2] <= in_data.target_blue;
		end
	end

	// Calibration state: levels and gains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CH; c++) begin
				low_q[c]  <= tplc_pkg::RESET_LOW[c];
				high_q[c] <= tplc_pkg::RESET_HIGH[c];
				gain_q[c] <= GB'((tplc_pkg::RESET_GAIN_Q16[c] << tplc_pkg::GAIN_UP)
					>> tplc_pkg::GAIN_DOWN);
			end
		end else begin
			for (int c = 0; c < CH; c++) begin
				if (cmd.cal_load) begin
					low_q[c]  <= new_low[c];
					high_q[c] <= new_high[c];
				end
				if (cmd.gain_write && upd_q[c]) begin
					gain_q[c] <= quo_q[c];
				end
			end
		end
	end

	// Serial dividers: full scale over the level span.
	always_ff @(posedge clk) begin
		for (int c = 0; c < CH; c++) begin
			if (cmd.cal_load) begin
				upd_q[c] <= new_high[c] > new_low[c];
				dvs_q[c] <= new_high[c] - new_low[c];
				rem_q[c] <= '0;
				quo_q[c] <= tplc_pkg::DIVIDEND;
			end else if (cmd.div_step) begin
				rem_q[c] <= rem_next[c];
				quo_q[c] <= {quo_q[c][GB-2:0], ge[c]};
			end
		end
	end

	// Gain times sample offset, zero at or below the low level.
	always_ff @(posedge clk) begin
		for (int c = 0; c < CH; c++) begin
			if (cmd.mul) begin
				if (samp_q[c] > low_q[c]) begin
					prod_s1[c] <= PB'(gain_q[c]) * PB'(samp_q[c] - low_q[c]);
				end else begin
					prod_s1[c] <= '0;
				end
			end
		end
	end

	// Result register with saturation to full scale.
	always_ff @(posedge clk) begin
		for (int c = 0; c < CH; c++) begin
			if (cmd.out_load) begin
				if (|prod_s1[c][PB-1:GB]) begin
					level_q[c] <= tplc_pkg::LEVEL_MAX;
				end else begin
					level_q[c] <= prod_s1[c][GB-1:FB];
				end
			end
		end
	end

	assign out_data.out_red   = level_q[0];
	assign out_data.out_green = level_q[1];
	assign out_data.out_blue  = level_q[2];

endmodule

`default_nettype wire

@@ rtl/core/tplc_ctrl.sv @@
// Controller: sequences calibration and apply items and owns the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module tplc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_kind,
	input  wire logic          out_ready,
	output logic               in_ready,
	output logic               out_valid,
	output tplc_pkg::tplc_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CAL,
		S_DIV,
		S_GAIN,
		S_MUL,
		S_EMIT
	} state_t;

	localparam logic [tplc_pkg::DIV_CNT_BITS-1:0] CNT_LAST =
		tplc_pkg::DIV_CNT_BITS'(tplc_pkg::DIV_STEPS - 1);

	state_t                            state_q;
	logic [tplc_pkg::DIV_CNT_BITS-1:0] cnt_q;
	logic                              out_valid_q;
	logic                              accept;
	logic                              emit;

	assign in_ready  = state_q == S_IDLE;
	assign accept    = in_valid && in_ready;
	assign emit      = (state_q == S_EMIT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// Command decode.
	always_comb begin
		cmd            = '0;
		cmd.in_load    = accept;
		cmd.cal_load   = state_q == S_CAL;
		cmd.div_step   = state_q == S_DIV;
		cmd.gain_write = state_q == S_GAIN;
		cmd.mul        = state_q == S_MUL;
		cmd.out_load   = emit;
	end

	// State, step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (in_kind == tplc_pkg::KIND_CAL) ? S_CAL : S_MUL;
					end
				end
				S_CAL: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= S_GAIN;
					end
				end
				S_GAIN: begin
					state_q <= S_IDLE;
				end
				S_MUL: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/two_point_level_calibration.sv @@
// Top level of the two-point level calibration block.
//
//   channel  direction  handshake            beat
//   in       input      in_valid / in_ready  tplc_pkg::in_t (kind, samples, targets)
//   out      output     out_valid/out_ready  tplc_pkg::out_t (calibrated levels)
//
// A calibration beat holds the input while it stores the levels, runs the bit-serial gain
// division (one quotient bit per cycle per channel) and then writes the gains.
// An apply beat multiplies, then loads the result register; it waits in the
// last step only while an earlier result is still held by out_ready low.
// Reset clears the controller and loads the default levels and gains at once.
// A new beat is taken while a finished result still waits on the output.
`timescale 1ns / 1ps
`default_nettype none

module two_point_level_calibration (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire tplc_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output tplc_pkg::out_t      out_data
);

	tplc_pkg::tplc_cmd_t cmd;

	// Sequencer.
	tplc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_kind   (in_data.kind),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// Arithmetic and state.
	tplc_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

	// A held result is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !cmd.out_load)
		else $error("result register overwritten while a beat is pending");

	// No input is taken while the divider runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !in_ready)
		else $error("input ready during gain division");

	// The gain write closes a calibration and frees the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gain_write |=> in_ready)
		else $error("input not ready after gain write");

	// A calibration beat never produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.kind == tplc_pkg::KIND_CAL) |=> !cmd.mul)
		else $error("multiply started for a calibration beat");

	// Datapath steps are exclusive.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.cal_load, cmd.div_step, cmd.gain_write, cmd.mul, cmd.out_load}))
		else $error("overlapping datapath commands");

endmodule

`default_nettype wire
